// ===== design/sci_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 update for the salted image check.
// No dependencies; used by sci_crc_lane and salted_crc32_image_check_core.
package sci_pkg;

  localparam int unsigned LANE_COUNT_DEF = 4;
  localparam int unsigned SALT_REGS      = 4;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned POS_W          = 5;
  localparam int unsigned MASK_W         = 4;
  localparam int unsigned STATUS_W       = 2;
  localparam logic [POS_W-1:0] HEADER_BYTES = 5'd16;
  localparam logic [POS_W-1:0] SALT_BYTES   = 5'd4;
  localparam logic [WORD_W-1:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [WORD_W-1:0] CRC_INIT    = 32'hFFFFFFFF;

  localparam logic [WORD_W-1:0] SALT0_RST = 32'hEFBEFECA;
  localparam logic [WORD_W-1:0] SALT1_RST = 32'hFEFEEFEF;
  localparam logic [WORD_W-1:0] SALT2_RST = 32'hCEFABEBA;
  localparam logic [WORD_W-1:0] SALT3_RST = 32'h0061F85A;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DAMAGED = 2'd1,
    STATUS_SHORT   = 2'd2
  } status_t;

  typedef struct packed {
    logic update;
    logic seed;
  } lane_ctl_t;

  function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] acc_in,
                                                 input logic [7:0] byte_in);
    logic [WORD_W-1:0] acc;
    acc = acc_in ^ {24'd0, byte_in};
    for (int k = 0; k < 8; k++) begin
      acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : '0);
    end
    return acc;
  endfunction

endpackage

// ===== design/salted_crc32_image_check_core.sv =====
// Salted CRC-32 boot image check: 16-byte header of expected words, then image bytes.
// Result: registered at the clock edge that accepts the last byte's request.
// One byte per cycle unless a waiting result stalls input; lane CRC update sets the cycle.
// Salt bytes are folded into the lanes during header bytes 0..3.
// Reset (rst, synchronous): position cleared, output empty, salts to their defaults.
// Depends on sci_pkg and sci_crc_lane.
module salted_crc32_image_check_core #(
  parameter int unsigned LANE_COUNT = sci_pkg::LANE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic                          s_tlast,   // last_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [1:0] check_status, [5:2] mismatch_mask
  input  logic                          cfg_we,
  input  logic [sci_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sci_pkg::WORD_W-1:0]    cfg_data
);

  logic [sci_pkg::WORD_W-1:0] salt     [sci_pkg::SALT_REGS];
  logic [sci_pkg::WORD_W-1:0] salt_lat [sci_pkg::SALT_REGS];
  logic [sci_pkg::WORD_W-1:0] expected [4];
  logic [7:0]                 salt_byte [sci_pkg::SALT_REGS];
  logic [sci_pkg::POS_W-1:0]  pos;
  logic                       accept;
  logic                       in_header;
  logic                       in_salt;
  sci_pkg::lane_ctl_t         lane_ctl;
  logic [LANE_COUNT-1:0]      mis;
  logic [sci_pkg::MASK_W-1:0] mask_w;
  sci_pkg::status_t           status;
  logic [sci_pkg::MASK_W-1:0] mask;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign in_header = pos < sci_pkg::HEADER_BYTES;
  assign in_salt   = pos < sci_pkg::SALT_BYTES;
  assign lane_ctl.seed   = pos == '0;
  assign lane_ctl.update = accept && (in_salt || !in_header);
  assign m_tdata  = {2'b00, mask, status};

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      salt[0] <= sci_pkg::SALT0_RST;
      salt[1] <= sci_pkg::SALT1_RST;
      salt[2] <= sci_pkg::SALT2_RST;
      salt[3] <= sci_pkg::SALT3_RST;
    end else if (cfg_we) begin
      salt[cfg_index] <= cfg_data;
    end
  end

  // salts are captured at image start so later writes wait for the next image
  always_ff @(posedge clk) begin
    if (accept && lane_ctl.seed) begin
      for (int r = 0; r < sci_pkg::SALT_REGS; r++) begin
        salt_lat[r] <= salt[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < sci_pkg::SALT_REGS; r++) begin
      salt_byte[r] = lane_ctl.seed ? salt[r][7:0] : salt_lat[r][{pos[1:0], 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_header) begin
      expected[pos[3:2]][{pos[1:0], 3'b000} +: 8] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        pos <= '0;
      end else if (in_header) begin
        pos <= pos + 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < LANE_COUNT; g++) begin : g_lane
      sci_crc_lane u_lane (
        .clk       (clk),
        .ctl       (lane_ctl),
        .feed_byte (in_salt ? salt_byte[g % sci_pkg::SALT_REGS] : s_tdata),
        .expected  (expected[g % 4]),
        .mismatch  (mis[g])
      );
    end
    for (g = 0; g < sci_pkg::MASK_W; g++) begin : g_mask
      if (g < LANE_COUNT) begin : g_used
        assign mask_w[g] = mis[g];
      end else begin : g_unused
        assign mask_w[g] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      if (in_header) begin
        status <= sci_pkg::STATUS_SHORT;
        mask   <= '0;
      end else begin
        status <= (|mis) ? sci_pkg::STATUS_DAMAGED : sci_pkg::STATUS_OK;
        mask   <= mask_w;
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= sci_pkg::HEADER_BYTES)
    else $error("byte position beyond header length");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> pos == '0)
    else $error("position not cleared after last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> m_tvalid)
    else $error("no result after last byte");

  a_mask_only_damaged: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != sci_pkg::STATUS_DAMAGED |-> mask == '0)
    else $error("mismatch mask set without damaged status");
`endif

endmodule

// ===== design/sci_crc_lane.sv =====
// One reflected CRC-32 lane: seeds from all ones, updates one byte per request,
// and flags a mismatch of the inverted next CRC against the expected word. Uses sci_pkg.
module sci_crc_lane (
  input  logic                        clk,
  input  sci_pkg::lane_ctl_t          ctl,
  input  logic [7:0]                  feed_byte,
  input  logic [sci_pkg::WORD_W-1:0]  expected,
  output logic                        mismatch
);

  logic [sci_pkg::WORD_W-1:0] crc;
  logic [sci_pkg::WORD_W-1:0] crc_base;
  logic [sci_pkg::WORD_W-1:0] crc_next;

  assign crc_base = ctl.seed ? sci_pkg::CRC_INIT : crc;
  assign crc_next = sci_pkg::crc_feed(crc_base, feed_byte);
  assign mismatch = (~crc_next) != expected;

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      crc <= crc_next;
    end
  end

endmodule

// ===== bench/salted_crc32_image_check_core_test.sv =====
// Self-checking bench for salted_crc32_image_check_core: streams boot images and predicts
// each check result per byte. Depends on sci_pkg and the core RTL.
module salted_crc32_image_check_core_test;

  localparam int unsigned LANES = sci_pkg::LANE_COUNT_DEF;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam logic [sci_pkg::CFG_IDX_W-1:0] REG_SALT0 = 2'd0;
  localparam logic [sci_pkg::CFG_IDX_W-1:0] REG_SALT1 = 2'd1;
  localparam logic [sci_pkg::CFG_IDX_W-1:0] REG_SALT2 = 2'd2;
  localparam logic [sci_pkg::CFG_IDX_W-1:0] REG_SALT3 = 2'd3;

  typedef struct packed {
    sci_pkg::status_t status;
    logic [3:0]       mask;
  } check_result_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [7:0]                    s_tdata;
  logic                          s_tlast;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [7:0]                    m_tdata;
  logic                          cfg_we;
  logic [sci_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sci_pkg::WORD_W-1:0]    cfg_data;

  // predictor state
  logic [sci_pkg::WORD_W-1:0] salt_reg[sci_pkg::SALT_REGS];
  logic [sci_pkg::WORD_W-1:0] lane_crc[LANES];
  logic [sci_pkg::WORD_W-1:0] hdr_word[4];
  logic [sci_pkg::POS_W-1:0]  img_pos;
  check_result_t              pending_checks[$];

  int error_count;
  int bytes_sent;
  int status_seen[3];
  int sender_idle_pct;
  int stall_pct;
  int hold_cycles;
  int quiet_cycles;

  salted_crc32_image_check_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [sci_pkg::WORD_W-1:0] crc_step(
      input logic [sci_pkg::WORD_W-1:0] acc, input logic [7:0] octet);
    logic [sci_pkg::WORD_W-1:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ octet[i]) r = (r >> 1) ^ 32'hEDB88320;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [sci_pkg::WORD_W-1:0] salted_seed(
      input logic [sci_pkg::WORD_W-1:0] salt);
    logic [sci_pkg::WORD_W-1:0] acc;
    acc = '1;
    for (int b = 0; b < 4; b++) acc = crc_step(acc, salt[8*b +: 8]);
    return acc;
  endfunction

  function automatic logic [7:0] rand_octet();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic predict_byte(input logic [7:0] octet, input logic last);
    logic          in_hdr;
    check_result_t res;
    in_hdr = (img_pos < sci_pkg::HEADER_BYTES);
    if (img_pos == '0)
      for (int l = 0; l < LANES; l++) lane_crc[l] = salted_seed(salt_reg[l % 4]);
    if (in_hdr) begin
      hdr_word[img_pos[3:2]][8*img_pos[1:0] +: 8] = octet;
      img_pos = img_pos + 1'b1;
    end else begin
      for (int l = 0; l < LANES; l++) lane_crc[l] = crc_step(lane_crc[l], octet);
    end
    if (last) begin
      img_pos = '0;
      res.mask = '0;
      if (in_hdr) begin
        res.status = sci_pkg::STATUS_SHORT;
      end else begin
        res.status = sci_pkg::STATUS_OK;
        for (int l = 0; l < LANES; l++)
          if (~lane_crc[l] != hdr_word[l % 4]) begin
            res.status = sci_pkg::STATUS_DAMAGED;
            if (l < 4) res.mask[l] = 1'b1;
          end
      end
      pending_checks.push_back(res);
    end
  endtask

  // one request on the input side; returns at the accepting edge
  task automatic send_byte(input logic [7:0] octet, input logic last);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= octet;
    s_tlast  <= last;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    predict_byte(octet, last);
    bytes_sent++;
  endtask

  task automatic send_short(input int len);
    for (int i = 0; i < len; i++) send_byte(rand_octet(), i == len - 1);
  endtask

  // header built from the current salts; corrupt flips one bit per flagged lane,
  // noise replaces the header with random words; fill < 0 means random payload
  task automatic send_image(input int payload_len, input logic [3:0] corrupt,
                            input bit noise, input int fill);
    logic [7:0]                 body[$];
    logic [sci_pkg::WORD_W-1:0] word[4];
    logic [sci_pkg::WORD_W-1:0] acc;
    body.delete();
    for (int i = 0; i < payload_len; i++)
      body.push_back(fill >= 0 ? 8'(fill) : rand_octet());
    for (int l = 0; l < 4; l++) begin
      acc = salted_seed(salt_reg[l]);
      foreach (body[i]) acc = crc_step(acc, body[i]);
      word[l] = ~acc;
      if (corrupt[l]) word[l] ^= 32'h1 << $urandom_range(31);
      if (noise) word[l] = $urandom;
    end
    for (int i = 0; i < 16; i++) send_byte(word[i / 4][8*(i % 4) +: 8], 1'b0);
    for (int i = 0; i < payload_len; i++) send_byte(body[i], i == payload_len - 1);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sci_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sci_pkg::WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    salt_reg[idx] = value;
  endtask

  task automatic program_salts(input logic [sci_pkg::WORD_W-1:0] s0,
                               input logic [sci_pkg::WORD_W-1:0] s1,
                               input logic [sci_pkg::WORD_W-1:0] s2,
                               input logic [sci_pkg::WORD_W-1:0] s3);
    settle();
    write_reg(REG_SALT0, s0);
    write_reg(REG_SALT1, s1);
    write_reg(REG_SALT2, s2);
    write_reg(REG_SALT3, s3);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_image();
    int pick;
    int len;
    pick = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
    if (pick < 15) begin
      case ($urandom_range(2))
        0: send_short(1);
        1: send_short(16);
        default: send_short($urandom_range(1, 16));
      endcase
    end else if (pick < 25) begin
      send_image(len, 4'h0, 1'b1, -1);
    end else begin
      send_image(len, ($urandom_range(1) == 0) ? 4'h0 : 4'($urandom_range(15)), 1'b0, -1);
    end
  endtask

  task automatic random_traffic(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) random_image();
  endtask

  // reset salts: shortest image, then the shortest full image
  task automatic test_directed();
    sender_idle_pct = 0;
    stall_pct = 0;
    send_byte(8'h00, 1'b1);
    send_image(1, 4'h0, 1'b0, 8'hFF);
    settle();
  endtask

  task automatic test_salt_extremes();
    program_salts('0, '0, '0, '0);
    send_image(1, 4'h0, 1'b0, 8'h00);
    send_image(3, 4'hF, 1'b0, -1);
    send_image(5, 4'h5, 1'b0, -1);
    program_salts('1, '1, '1, '1);
    send_image(2, 4'h0, 1'b0, 8'hFF);
    send_image(4, 4'hA, 1'b0, -1);
    send_short(16);
    program_salts('0, '1, sci_pkg::SALT2_RST, sci_pkg::SALT3_RST);
    send_image(6, 4'h3, 1'b0, -1);
    send_image(2, 4'h0, 1'b0, -1);
    settle();
  endtask

  task automatic test_idle_phases();
    for (int phase = 0; phase < 4; phase++) begin
      program_salts($urandom, $urandom, $urandom, $urandom);
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 55; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 55; end
        default: begin sender_idle_pct = 33; stall_pct = 33; end
      endcase
      random_traffic(320);
      settle();
    end
  endtask

  // receiver holds off while short images keep arriving; input must stall
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    for (int i = 0; i < 10; i++) send_short(1);
    send_image(3, 4'h0, 1'b0, -1);
    settle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    check_result_t want;
    logic [1:0]    got_status;
    logic [3:0]    got_mask;
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got_status = m_tdata[1:0];
        got_mask   = m_tdata[5:2];
        if (pending_checks.size() == 0) begin
          $error("unexpected result: check_status %0d, mismatch_mask %0h",
                 got_status, got_mask);
          error_count++;
        end else begin
          want = pending_checks.pop_front();
          if (got_status != want.status) begin
            $error("check_status: expected %0d, got %0d", want.status, got_status);
            error_count++;
          end
          if (got_mask != want.mask) begin
            $error("mismatch_mask: expected %0h, got %0h", want.mask, got_mask);
            error_count++;
          end
          if (want.status <= sci_pkg::STATUS_SHORT) status_seen[want.status]++;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(negedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    hold_cycles = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    error_count = 0;
    bytes_sent = 0;
    status_seen = '{0, 0, 0};
    salt_reg = '{sci_pkg::SALT0_RST, sci_pkg::SALT1_RST,
                 sci_pkg::SALT2_RST, sci_pkg::SALT3_RST};
    hdr_word = '{'0, '0, '0, '0};
    img_pos = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_salt_extremes();
    test_idle_phases();
    test_output_backpressure();

    settle();
    repeat (8) @(posedge clk);
    if (pending_checks.size() != 0) begin
      $error("%0d expected results never arrived", pending_checks.size());
      error_count++;
    end
    $display("Sent %0d image bytes; checked %0d ok, %0d damaged, %0d short results",
             bytes_sent, status_seen[0], status_seen[1], status_seen[2]);
    $display("across reset, extreme and random salts with idle, stall and hold-off phases");
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
